[rtl/ssp_pkg.sv]
// Shared types for the stable sign partition block.
`timescale 1ns / 1ps

package ssp_pkg;

  // Control sequencer: loading, then one drain phase per sign group
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_NEG,
    ST_ZERO,
    ST_POS
  } state_t;

  // Which group a result in flight belongs to
  typedef enum logic [1:0] {
    KIND_NEG,
    KIND_ZERO,
    KIND_POS
  } kind_t;

endpackage

[rtl/ssp_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module ssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/stable_sign_partition_top.sv]
// Top level of the stable sign partition block: load sequencer, drain sequencer, output queue.
`timescale 1ns / 1ps

// Collects a sequence of signed values (in_tlast marks the final one) and then
// replays it reordered: all negatives, then all zeros, then all positives, each
// group in arrival order. Loading takes one transaction per cycle; negatives and
// positives are written into two RAMs, zeros are only counted. Once the final
// item is taken the input stalls while the drain issues one entry per cycle
// whenever the two-entry output queue has room (zeros need no RAM read), so
// results leave at one per cycle when out_tready stays high, with a gap at
// each of the three group boundaries. Items beyond CAPACITY are dropped and
// every result of that sequence carries out_tuser (overflow) set. The input
// reopens in the cycle after the last group boundary, while queued results
// still drain.
module stable_sign_partition_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   in_tdata,   // [VALUE_WIDTH-1:0] value
  input  logic                               in_tlast,   // last
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]   out_tdata,  // [VALUE_WIDTH-1:0] value_res
  output logic                               out_tlast,  // last_res
  output logic                               out_tuser   // overflow
);

  import ssp_pkg::*;

  localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Sequencer and counters
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       neg_cnt_r, neg_cnt_nxt;
  logic [CNT_W-1:0]       zero_cnt_r, zero_cnt_nxt;
  logic [CNT_W-1:0]       pos_cnt_r, pos_cnt_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   ovf_r, ovf_nxt;

  // Read in flight
  logic                   s1_v_r;
  kind_t                  s1_kind_r;
  logic                   s1_last_r;
  logic                   s1_ovf_r;

  // Two-entry output queue
  logic [VALUE_WIDTH-1:0] fv_r [2];
  logic                   fl_r [2];
  logic                   fo_r [2];
  logic                   rd_ptr_r, wr_ptr_r;
  logic [1:0]             q_cnt_r;

  // Combinational
  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [CNT_W-1:0]       held;
  logic                   store_ok;
  logic                   is_zero;
  logic                   is_neg;
  logic                   neg_we;
  logic                   pos_we;
  logic [CNT_W-1:0]       phase_cnt;
  logic [CNT_W-1:0]       idx_inc;
  logic                   phase_done;
  logic                   issue;
  logic                   issue_last;
  kind_t                  issue_kind;
  logic                   pop;
  logic                   push;
  logic [1:0]             credits;
  logic                   credit_ok;
  logic [VALUE_WIDTH-1:0] neg_rdata;
  logic [VALUE_WIDTH-1:0] pos_rdata;
  logic [VALUE_WIDTH-1:0] land_value;

  // Load side classification
  assign in_fire  = in_tvalid && in_tready;
  assign in_value = in_tdata[VALUE_WIDTH-1:0];
  assign held     = neg_cnt_r + zero_cnt_r + pos_cnt_r;
  assign store_ok = (held < CNT_W'(CAPACITY));
  assign is_zero  = (in_value == '0);
  assign is_neg   = in_value[VALUE_WIDTH-1];
  assign neg_we   = in_fire && store_ok && is_neg;
  assign pos_we   = in_fire && store_ok && !is_neg && !is_zero;

  // Drain side bookkeeping
  assign idx_inc    = idx_r + CNT_W'(1);
  assign phase_done = (idx_r == phase_cnt);

  always_comb begin
    case (state_r)
      ST_NEG: begin
        phase_cnt  = neg_cnt_r;
        issue_kind = KIND_NEG;
        issue_last = (idx_inc == neg_cnt_r) && (zero_cnt_r == '0) && (pos_cnt_r == '0);
      end
      ST_ZERO: begin
        phase_cnt  = zero_cnt_r;
        issue_kind = KIND_ZERO;
        issue_last = (idx_inc == zero_cnt_r) && (pos_cnt_r == '0);
      end
      ST_POS: begin
        phase_cnt  = pos_cnt_r;
        issue_kind = KIND_POS;
        issue_last = (idx_inc == pos_cnt_r);
      end
      default: begin
        phase_cnt  = '0;
        issue_kind = KIND_ZERO;
        issue_last = 1'b0;
      end
    endcase
  end

  // Queue credit: entries held plus read in flight, after this cycle's pop
  assign pop       = out_tvalid && out_tready;
  assign push      = s1_v_r;
  assign credits   = q_cnt_r + {1'b0, s1_v_r} - {1'b0, pop};
  assign credit_ok = (credits < 2'd2);

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
      end
      ST_NEG, ST_ZERO, ST_POS: begin
        issue = !phase_done && credit_ok;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_tlast) begin
          state_nxt = ST_NEG;
        end
      end
      ST_NEG: begin
        if (phase_done) begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (phase_done) begin
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        if (phase_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Counter and index updates
  always_comb begin
    neg_cnt_nxt  = neg_cnt_r;
    zero_cnt_nxt = zero_cnt_r;
    pos_cnt_nxt  = pos_cnt_r;
    ovf_nxt      = ovf_r;
    idx_nxt      = idx_r;
    if (in_fire) begin
      if (!store_ok) begin
        ovf_nxt = 1'b1;
      end else if (is_zero) begin
        zero_cnt_nxt = zero_cnt_r + CNT_W'(1);
      end else if (is_neg) begin
        neg_cnt_nxt = neg_cnt_r + CNT_W'(1);
      end else begin
        pos_cnt_nxt = pos_cnt_r + CNT_W'(1);
      end
    end
    if (issue) begin
      idx_nxt = idx_inc;
    end else if (phase_done) begin
      idx_nxt = '0;
    end
    // End of drain: ready for the next sequence
    if (state_r == ST_POS && phase_done) begin
      neg_cnt_nxt  = '0;
      zero_cnt_nxt = '0;
      pos_cnt_nxt  = '0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      neg_cnt_r  <= '0;
      zero_cnt_r <= '0;
      pos_cnt_r  <= '0;
      idx_r      <= '0;
      ovf_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      neg_cnt_r  <= neg_cnt_nxt;
      zero_cnt_r <= zero_cnt_nxt;
      pos_cnt_r  <= pos_cnt_nxt;
      idx_r      <= idx_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Value stores; writes only while loading, reads only while draining
  ssp_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_neg_ram (
    .clk   (clk),
    .we    (neg_we),
    .waddr (neg_cnt_r[AW-1:0]),
    .wdata (in_value),
    .re    (issue && (issue_kind == KIND_NEG)),
    .raddr (idx_r[AW-1:0]),
    .rdata (neg_rdata)
  );

  ssp_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_cnt_r[AW-1:0]),
    .wdata (in_value),
    .re    (issue && (issue_kind == KIND_POS)),
    .raddr (idx_r[AW-1:0]),
    .rdata (pos_rdata)
  );

  // Read in flight tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r <= issue_kind;
      s1_last_r <= issue_last;
      s1_ovf_r  <= ovf_r;
    end
  end

  // Pick the landing value; zeros never touch a RAM
  always_comb begin
    case (s1_kind_r)
      KIND_NEG: land_value = neg_rdata;
      KIND_POS: land_value = pos_rdata;
      default:  land_value = '0;
    endcase
  end

  // Output queue
  always_ff @(posedge clk) begin
    if (push) begin
      fv_r[wr_ptr_r] <= land_value;
      fl_r[wr_ptr_r] <= s1_last_r;
      fo_r[wr_ptr_r] <= s1_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = DATA_W'(fv_r[rd_ptr_r]);
  assign out_tlast  = fl_r[rd_ptr_r];
  assign out_tuser  = fo_r[rd_ptr_r];

  // Queue never takes a transaction it has no room for
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> q_cnt_r < 2'd2)
    else $error("output queue overrun");

  // Reads stay inside the part of the store filled this sequence
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (idx_r < phase_cnt) && (state_r != ST_LOAD))
    else $error("drain read beyond stored entries");

  // Items held never exceed the store capacity
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held <= CNT_W'(CAPACITY))
    else $error("held count beyond capacity");

  // No store write while a drain read is issued or in flight
  a_no_load_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (neg_we || pos_we) |-> !issue && !s1_v_r)
    else $error("store write during drain read");

endmodule
